@@ design/multi_motor_position_unwrap_defines.svh @@
// Assertion macros for the motor position unwrap block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MULTI_MOTOR_POSITION_UNWRAP_DEFINES_SVH
`define MULTI_MOTOR_POSITION_UNWRAP_DEFINES_SVH
`ifndef SYNTHESIS
`define MMPU_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
`define MMPU_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MMPU_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg)
`define MMPU_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

@@ design/mmpu_pkg.sv @@
// Shared types, codes and helpers for the motor position unwrap block.
// No dependencies; used by every module of the block.
package mmpu_pkg;

  localparam int MOTOR_COUNT_DEF = 6;
  localparam int ID_SLOTS        = 6;
  localparam int ID_W            = 8;
  localparam int SLOT_W          = 3;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [20:0] WRAP_RANGE_RST = 21'd1647099;
  localparam logic [19:0] WRAP_HALF_RST  = 20'd823550;
  localparam logic [15:0] TIMEOUT_RST    = 16'd1000;

  typedef enum logic [1:0] {
    CMD_FEEDBACK = 2'd0,
    CMD_REHOME   = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_RESERVED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_FEED = 2'd0,
    OP_HOME = 2'd1,
    OP_TICK = 2'd2,
    OP_SKIP = 2'd3
  } op_code_t;

  typedef enum logic [1:0] {
    KIND_UPDATED = 2'd0,
    KIND_IGNORED = 2'd1,
    KIND_REHOMED = 2'd2,
    KIND_TICK    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_ID_TABLE   = 3'd0,
    REG_REVERSED   = 3'd1,
    REG_WRAP_RANGE = 3'd2,
    REG_WRAP_HALF  = 3'd3,
    REG_TIMEOUT    = 3'd4
  } reg_t;

  typedef struct packed {
    logic [ID_SLOTS*ID_W-1:0] id_table;
    logic [ID_SLOTS-1:0]      reversed;
    logic [20:0]              wrap_range;
    logic [19:0]              wrap_half;
    logic [15:0]              timeout;
  } cfg_t;

  typedef struct packed {
    op_code_t           code;
    logic [SLOT_W-1:0]  slot;
    logic signed [31:0] abs_position;
    logic signed [20:0] wrapped_position;
    logic signed [23:0] velocity;
    logic signed [23:0] torque;
    logic [15:0]        temperature;
    logic [15:0]        error_bits;
    logic               fault;
  } op_t;

  typedef struct packed {
    kind_t               kind;
    logic [SLOT_W-1:0]   slot;
    logic signed [31:0]  position;
    logic signed [23:0]  velocity;
    logic signed [23:0]  torque;
    logic [15:0]         temperature;
    logic [15:0]         error_bits;
    logic                fault;
    logic [ID_SLOTS-1:0] online;
  } res_t;

  // negate with saturation of the most negative code
  function automatic logic signed [23:0] neg24(input logic signed [23:0] v);
    logic signed [23:0] r;
    if (v == 24'sh800000) begin
      r = 24'sh7FFFFF;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

@@ design/mmpu_fifo.sv @@
// Small register queue with push/full and pop/empty sides.
// Depends on the assertion macro header; DEPTH must be a power of two.
`include "multi_motor_position_unwrap_defines.svh"
module mmpu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mmpu_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wptr;
  logic [PtrW-1:0]  rptr;
  logic [CntW-1:0]  count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        wptr <= wptr + 1'b1;
      end
      if (pop_ok) begin
        rptr <= rptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wptr] <= wdata;
    end
  end

  `MMPU_ASSERT_NXT(a_fifo_fill, clk, rst, push_ok && !pop_ok, count == $past(count) + 1'b1, "queue count did not advance on push")
endmodule

@@ design/mmpu_front.sv @@
// Front end: classifies an incoming item and matches feedback to a motor slot.
// Depends on mmpu_pkg for the configuration and operation types.
module mmpu_front #(
  parameter int MOTOR_COUNT = mmpu_pkg::MOTOR_COUNT_DEF
) (
  input  mmpu_pkg::cfg_t     cfg,
  input  logic [1:0]         command,
  input  logic [7:0]         bus_id,
  input  logic [2:0]         motor_index,
  input  logic signed [31:0] abs_position,
  input  logic signed [20:0] wrapped_position,
  input  logic signed [23:0] velocity_in,
  input  logic signed [23:0] torque_in,
  input  logic [15:0]        temperature_in,
  input  logic [15:0]        error_bits_in,
  input  logic               fault_in,
  output mmpu_pkg::op_t      op
);
  import mmpu_pkg::*;

  logic              hit;
  logic [SLOT_W-1:0] hit_slot;

  // lowest matching slot wins: scan from the top down
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = ID_SLOTS - 1; i >= 0; i--) begin
      if (i < MOTOR_COUNT && cfg.id_table[i*ID_W +: ID_W] == bus_id) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    op = '0;
    op.code = OP_SKIP;
    case (cmd_t'(command))
      CMD_FEEDBACK: begin
        if (hit) begin
          op.code             = OP_FEED;
          op.slot             = hit_slot;
          op.wrapped_position = wrapped_position;
          op.velocity         = velocity_in;
          op.torque           = torque_in;
          op.temperature      = temperature_in;
          op.error_bits       = error_bits_in;
          op.fault            = fault_in;
        end
      end
      CMD_REHOME: begin
        if (int'(motor_index) < MOTOR_COUNT) begin
          op.code         = OP_HOME;
          op.slot         = motor_index;
          op.abs_position = abs_position;
        end
      end
      CMD_TICK: begin
        op.code = OP_TICK;
      end
      default: begin
        op.code = OP_SKIP;
      end
    endcase
  end
endmodule

@@ design/mmpu_back.sv @@
// Back end: per-motor unwrap state, rehome, tick timeouts and result assembly.
// Depends on mmpu_pkg and the assertion macro header.
`include "multi_motor_position_unwrap_defines.svh"
module mmpu_back #(
  parameter int MOTOR_COUNT = mmpu_pkg::MOTOR_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  mmpu_pkg::cfg_t cfg,
  input  mmpu_pkg::op_t  op,
  input  logic           op_empty,
  output logic           op_pop,
  output mmpu_pkg::res_t res,
  output logic           res_push,
  input  logic           res_full
);
  import mmpu_pkg::*;

  localparam int IdxW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  typedef enum logic [1:0] {
    B_EXEC = 2'b01,
    B_DONE = 2'b10
  } bstate_t;

  bstate_t state;
  bstate_t state_next;

  logic signed [20:0]     prev_raw  [MOTOR_COUNT];
  logic [31:0]            wrap_off  [MOTOR_COUNT];
  logic [31:0]            home_off  [MOTOR_COUNT];
  logic [31:0]            last_seen [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] seen;
  logic [MOTOR_COUNT-1:0] online;
  logic [31:0]            tick_count;

  op_t         cur;
  logic [31:0] cur_off;

  logic [IdxW-1:0]    idx_in;
  logic [IdxW-1:0]    cur_idx;
  logic [31:0]        raw_ext;
  logic signed [21:0] delta;
  logic signed [21:0] half_pos;
  logic signed [21:0] half_neg;
  logic [31:0]        woff_new;

  logic [31:0]            pos;
  logic                   rev;
  logic [MOTOR_COUNT-1:0] expired;
  logic [MOTOR_COUNT-1:0] online_view;
  logic [ID_SLOTS+MOTOR_COUNT-1:0] online_pad;

  assign idx_in  = IdxW'(op.slot);
  assign cur_idx = IdxW'(cur.slot);
  assign op_pop   = (state == B_EXEC) && !op_empty;
  assign res_push = (state == B_DONE) && !res_full;

  // offset update for the frame at the head of the queue
  always_comb begin
    raw_ext  = {{11{op.wrapped_position[20]}}, op.wrapped_position};
    delta    = {op.wrapped_position[20], op.wrapped_position}
             - {prev_raw[idx_in][20], prev_raw[idx_in]};
    half_pos = {2'b00, cfg.wrap_half};
    half_neg = -half_pos;
    if (!seen[idx_in]) begin
      woff_new = home_off[idx_in] - raw_ext;
    end else if (delta > half_pos) begin
      woff_new = wrap_off[idx_in] - {11'b0, cfg.wrap_range};
    end else if (delta < half_neg) begin
      woff_new = wrap_off[idx_in] + {11'b0, cfg.wrap_range};
    end else begin
      woff_new = wrap_off[idx_in];
    end
  end

  // timeout test runs on the already advanced tick count
  always_comb begin
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      expired[i] = (tick_count - last_seen[i]) > {16'b0, cfg.timeout};
    end
    if (cur.code == OP_TICK) begin
      online_view = online & ~expired;
    end else begin
      online_view = online;
    end
    online_pad = {{ID_SLOTS{1'b0}}, online_view};
  end

  always_comb begin
    pos = {{11{cur.wrapped_position[20]}}, cur.wrapped_position} + cur_off;
    rev = (cur.slot < SLOT_W'(ID_SLOTS)) && cfg.reversed[cur.slot];
    res = '0;
    res.kind   = KIND_IGNORED;
    res.online = online_pad[ID_SLOTS-1:0];
    case (cur.code)
      OP_FEED: begin
        res.kind        = KIND_UPDATED;
        res.slot        = cur.slot;
        res.position    = rev ? (32'd0 - pos) : pos;
        res.velocity    = rev ? neg24(cur.velocity) : cur.velocity;
        res.torque      = rev ? neg24(cur.torque) : cur.torque;
        res.temperature = cur.temperature;
        res.error_bits  = cur.error_bits;
        res.fault       = cur.fault;
      end
      OP_HOME: begin
        res.kind     = KIND_REHOMED;
        res.slot     = cur.slot;
        res.position = cur.abs_position;
      end
      OP_TICK: begin
        res.kind = KIND_TICK;
      end
      default: begin
        res.kind = KIND_IGNORED;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      B_EXEC: begin
        if (op_pop) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (res_push) begin
          state_next = B_EXEC;
        end
      end
      default: begin
        state_next = B_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_EXEC;
      seen       <= '0;
      online     <= '0;
      tick_count <= '0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        home_off[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (op_pop) begin
        case (op.code)
          OP_FEED: begin
            seen[idx_in]   <= 1'b1;
            online[idx_in] <= 1'b1;
          end
          OP_HOME: begin
            home_off[idx_in] <= op.abs_position;
            seen[idx_in]     <= 1'b0;
          end
          OP_TICK: begin
            tick_count <= tick_count + 32'd1;
          end
          default: begin
          end
        endcase
      end
      if (res_push && cur.code == OP_TICK) begin
        online <= online_view;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      cur     <= op;
      cur_off <= woff_new;
      case (op.code)
        OP_FEED: begin
          prev_raw[idx_in]  <= op.wrapped_position;
          wrap_off[idx_in]  <= woff_new;
          last_seen[idx_in] <= tick_count;
        end
        OP_HOME: begin
          prev_raw[idx_in] <= '0;
          wrap_off[idx_in] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  `MMPU_ASSERT_NOW(a_hold_in_done, clk, rst, state == B_DONE, !op_pop, "pop while result pending")
  `MMPU_ASSERT_NXT(a_feed_online, clk, rst, op_pop && op.code == OP_FEED, online[cur_idx], "feed not online")
  `MMPU_ASSERT_NXT(a_tick_no_set, clk, rst, res_push && cur.code == OP_TICK, (online & ~$past(online)) == '0, "tick set online")
endmodule

@@ design/multi_motor_position_unwrap.sv @@
// Multi-turn position unwrap for up to MOTOR_COUNT bus motors.
// Each item passes through the operation queue, the back end and the result queue.
// The back end handles one item at a time in two steps (offset update, then position and
// direction correction) and takes no new item while a result waits; both queues hold 2 entries.
// Reset (rst, synchronous): queues empty, registers to defaults, motors unhomed and offline.
module multi_motor_position_unwrap #(
  parameter int MOTOR_COUNT = mmpu_pkg::MOTOR_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         command,
  input  logic [7:0]         bus_id,
  input  logic [2:0]         motor_index,
  input  logic signed [31:0] abs_position,
  input  logic signed [20:0] wrapped_position,
  input  logic signed [23:0] velocity_in,
  input  logic signed [23:0] torque_in,
  input  logic [15:0]        temperature_in,
  input  logic [15:0]        error_bits_in,
  input  logic               fault_in,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         result_kind,
  output logic [2:0]         motor_slot,
  output logic signed [31:0] position_out,
  output logic signed [23:0] velocity_out,
  output logic signed [23:0] torque_out,
  output logic [15:0]        temperature_out,
  output logic [15:0]        error_bits_out,
  output logic               fault_out,
  output logic [5:0]         online_mask
);
  import mmpu_pkg::*;

  cfg_t cfg;
  op_t  op_in;
  op_t  op_head;
  logic op_empty;
  logic op_pop;
  res_t res_in;
  res_t res_head;
  logic res_push;
  logic res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.id_table   <= '0;
      cfg.reversed   <= '0;
      cfg.wrap_range <= WRAP_RANGE_RST;
      cfg.wrap_half  <= WRAP_HALF_RST;
      cfg.timeout    <= TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (reg_t'(cfg_index))
        REG_ID_TABLE:   cfg.id_table   <= cfg_data;
        REG_REVERSED:   cfg.reversed   <= cfg_data[5:0];
        REG_WRAP_RANGE: cfg.wrap_range <= cfg_data[20:0];
        REG_WRAP_HALF:  cfg.wrap_half  <= cfg_data[19:0];
        REG_TIMEOUT:    cfg.timeout    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  mmpu_front #(.MOTOR_COUNT(MOTOR_COUNT)) u_front (
    .cfg              (cfg),
    .command          (command),
    .bus_id           (bus_id),
    .motor_index      (motor_index),
    .abs_position     (abs_position),
    .wrapped_position (wrapped_position),
    .velocity_in      (velocity_in),
    .torque_in        (torque_in),
    .temperature_in   (temperature_in),
    .error_bits_in    (error_bits_in),
    .fault_in         (fault_in),
    .op               (op_in)
  );

  mmpu_fifo #(.WIDTH($bits(op_t)), .DEPTH(QUEUE_DEPTH)) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (op_in),
    .full  (full),
    .pop   (op_pop),
    .rdata (op_head),
    .empty (op_empty)
  );

  mmpu_back #(.MOTOR_COUNT(MOTOR_COUNT)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op       (op_head),
    .op_empty (op_empty),
    .op_pop   (op_pop),
    .res      (res_in),
    .res_push (res_push),
    .res_full (res_full)
  );

  mmpu_fifo #(.WIDTH($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign result_kind     = res_head.kind;
  assign motor_slot      = res_head.slot;
  assign position_out    = res_head.position;
  assign velocity_out    = res_head.velocity;
  assign torque_out      = res_head.torque;
  assign temperature_out = res_head.temperature;
  assign error_bits_out  = res_head.error_bits;
  assign fault_out       = res_head.fault;
  assign online_mask     = res_head.online;
endmodule

@@ test/mmpu_checker.sv @@
// Checker for the motor position unwrap block: watches config writes and both queue
// channels, predicts every result beat and compares it field by field.
// Depends on mmpu_pkg for the code enums and the result struct.
module mmpu_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         command,
  input  logic [7:0]         bus_id,
  input  logic [2:0]         motor_index,
  input  logic signed [31:0] abs_position,
  input  logic signed [20:0] wrapped_position,
  input  logic signed [23:0] velocity_in,
  input  logic signed [23:0] torque_in,
  input  logic [15:0]        temperature_in,
  input  logic [15:0]        error_bits_in,
  input  logic               fault_in,
  input  logic               empty,
  input  logic               pop,
  input  logic [1:0]         result_kind,
  input  logic [2:0]         motor_slot,
  input  logic signed [31:0] position_out,
  input  logic signed [23:0] velocity_out,
  input  logic signed [23:0] torque_out,
  input  logic [15:0]        temperature_out,
  input  logic [15:0]        error_bits_out,
  input  logic               fault_out,
  input  logic [5:0]         online_mask,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mmpu_pkg::*;

  localparam int MOTORS = MOTOR_COUNT_DEF;
  localparam int SHOWN  = 100;

  logic [47:0]        id_tab;
  logic [5:0]         rev_mask;
  logic [20:0]        range_r;
  logic [19:0]        half_r;
  logic [15:0]        timeout_r;

  logic signed [20:0] prev_raw [MOTORS];
  logic [31:0]        wrap_ofs [MOTORS];
  logic [31:0]        home_ofs [MOTORS];
  logic [31:0]        last_seen [MOTORS];
  logic [MOTORS-1:0]  seen;
  logic [MOTORS-1:0]  online;
  logic [31:0]        ticks;

  res_t motor_reports_q[$];
  int   errors = 0;
  int   beats = 0;

  assign fail_count = errors;

  task automatic report(string msg);
    if (errors < SHOWN) $display("[%0t] result beat %0d: %s", $time, beats, msg);
    errors++;
  endtask

  // negate, clamping the most negative code to the most positive
  function automatic logic signed [23:0] flip24(logic signed [23:0] v);
    return (v == 24'h800000) ? 24'h7FFFFF : -v;
  endfunction

  function automatic res_t unwrap_step();
    res_t               r;
    int                 hit;
    logic signed [31:0] raw32;
    logic [31:0]        pos;
    longint             jump;
    logic signed [23:0] vel;
    logic signed [23:0] tq;
    r = '0;
    r.kind = KIND_IGNORED;
    hit = -1;
    case (cmd_t'(command))
      CMD_FEEDBACK: begin
        // scan downward so the lowest matching motor wins
        for (int i = MOTORS - 1; i >= 0; i--) begin
          if (id_tab[8*i +: 8] == bus_id) hit = i;
        end
        if (hit >= 0) begin
          raw32 = wrapped_position;
          if (!seen[hit]) begin
            wrap_ofs[hit] = home_ofs[hit] - raw32;
            seen[hit] = 1'b1;
          end else begin
            jump = longint'(wrapped_position) - longint'(prev_raw[hit]);
            if (jump > longint'(half_r)) wrap_ofs[hit] = wrap_ofs[hit] - {11'd0, range_r};
            else if (jump < -longint'(half_r)) wrap_ofs[hit] = wrap_ofs[hit] + {11'd0, range_r};
          end
          prev_raw[hit] = wrapped_position;
          pos = raw32 + wrap_ofs[hit];
          vel = velocity_in;
          tq = torque_in;
          if (rev_mask[hit]) begin
            pos = -pos;
            vel = flip24(vel);
            tq = flip24(tq);
          end
          online[hit] = 1'b1;
          last_seen[hit] = ticks;
          r.kind = KIND_UPDATED;
          r.slot = 3'(hit);
          r.position = pos;
          r.velocity = vel;
          r.torque = tq;
          r.temperature = temperature_in;
          r.error_bits = error_bits_in;
          r.fault = fault_in;
        end
      end
      CMD_REHOME: begin
        if (motor_index < MOTORS) begin
          home_ofs[motor_index] = abs_position;
          prev_raw[motor_index] = '0;
          wrap_ofs[motor_index] = '0;
          seen[motor_index] = 1'b0;
          r.kind = KIND_REHOMED;
          r.slot = motor_index;
          r.position = abs_position;
        end
      end
      CMD_TICK: begin
        ticks = ticks + 1;
        for (int i = 0; i < MOTORS; i++) begin
          if (online[i] && (ticks - last_seen[i]) > {16'd0, timeout_r}) online[i] = 1'b0;
        end
        r.kind = KIND_TICK;
      end
      default: ;
    endcase
    r.online = online[ID_SLOTS-1:0];
    return r;
  endfunction

  task automatic check_beat();
    res_t want;
    if (motor_reports_q.size() == 0) begin
      report("result beat with nothing predicted");
      return;
    end
    want = motor_reports_q.pop_front();
    if (result_kind !== want.kind)
      report($sformatf("result_kind %0d, want %0d", result_kind, want.kind));
    if (motor_slot !== want.slot)
      report($sformatf("motor_slot %0d, want %0d", motor_slot, want.slot));
    if (position_out !== want.position)
      report($sformatf("position_out %0d, want %0d", position_out, want.position));
    if (velocity_out !== want.velocity)
      report($sformatf("velocity_out %0d, want %0d", velocity_out, want.velocity));
    if (torque_out !== want.torque)
      report($sformatf("torque_out %0d, want %0d", torque_out, want.torque));
    if (temperature_out !== want.temperature)
      report($sformatf("temperature_out %h, want %h", temperature_out, want.temperature));
    if (error_bits_out !== want.error_bits)
      report($sformatf("error_bits_out %h, want %h", error_bits_out, want.error_bits));
    if (fault_out !== want.fault)
      report($sformatf("fault_out %b, want %b", fault_out, want.fault));
    if (online_mask !== want.online)
      report($sformatf("online_mask %b, want %b", online_mask, want.online));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      id_tab = '0;
      rev_mask = '0;
      range_r = WRAP_RANGE_RST;
      half_r = WRAP_HALF_RST;
      timeout_r = TIMEOUT_RST;
      for (int i = 0; i < MOTORS; i++) begin
        prev_raw[i] = '0;
        wrap_ofs[i] = '0;
        home_ofs[i] = '0;
        last_seen[i] = '0;
      end
      seen = '0;
      online = '0;
      ticks = '0;
      motor_reports_q.delete();
      pending <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (reg_t'(cfg_index))
          REG_ID_TABLE:   id_tab = cfg_data;
          REG_REVERSED:   rev_mask = cfg_data[5:0];
          REG_WRAP_RANGE: range_r = cfg_data[20:0];
          REG_WRAP_HALF:  half_r = cfg_data[19:0];
          REG_TIMEOUT:    timeout_r = cfg_data[15:0];
          default: ;
        endcase
      end
      // compare before predicting so a beat never matches an item taken at the same edge
      if (pop && !empty) begin
        check_beat();
        beats++;
      end
      if (push && !full) motor_reports_q.push_back(unwrap_step());
      pending <= motor_reports_q.size();
    end
  end

endmodule

@@ test/tb_multi_motor_position_unwrap.sv @@
// Testbench top for multi_motor_position_unwrap: clock, reset, config phases,
// directed and random feedback/rehome/tick traffic, result draining and the verdict.
// Depends on mmpu_pkg and the mmpu_checker module.
module tb_multi_motor_position_unwrap;
  timeunit 1ns;
  timeprecision 1ps;
  import mmpu_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 135;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [2:0]         cfg_index;
  logic [47:0]        cfg_data;
  logic               push;
  logic               full;
  logic [1:0]         command;
  logic [7:0]         bus_id;
  logic [2:0]         motor_index;
  logic signed [31:0] abs_position;
  logic signed [20:0] wrapped_position;
  logic signed [23:0] velocity_in;
  logic signed [23:0] torque_in;
  logic [15:0]        temperature_in;
  logic [15:0]        error_bits_in;
  logic               fault_in;
  logic               empty;
  logic               pop;
  logic [1:0]         result_kind;
  logic [2:0]         motor_slot;
  logic signed [31:0] position_out;
  logic signed [23:0] velocity_out;
  logic signed [23:0] torque_out;
  logic [15:0]        temperature_out;
  logic [15:0]        error_bits_out;
  logic               fault_out;
  logic [5:0]         online_mask;
  int                 fail_count;
  int                 pending;

  int                 cycles = 0;
  int                 push_burst = 0;
  int                 pop_burst = 0;
  logic [47:0]        cur_ids;
  logic [20:0]        walker [6];

  multi_motor_position_unwrap dut (.*);
  mmpu_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_multi_motor_position_unwrap: FAIL");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int idle_len(ref int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [23:0] rand24();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 24'h800000;
    if (r == 1) return 24'h7FFFFF;
    return 24'($urandom());
  endfunction

  function automatic logic [47:0] rand_ids(int span);
    logic [47:0] t;
    for (int b = 0; b < 6; b++) t[8*b +: 8] = 8'($urandom_range(0, span));
    return t;
  endfunction

  // hold the beat until the block takes it
  task automatic send(cmd_t c, logic [7:0] id, logic [2:0] idx, logic [31:0] abs_p,
                      logic [20:0] raw, logic [23:0] vel, logic [23:0] tq,
                      logic [15:0] temp, logic [15:0] err, logic flt);
    int n;
    n = idle_len(push_burst);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
    command <= c;
    bus_id <= id;
    motor_index <= idx;
    abs_position <= abs_p;
    wrapped_position <= raw;
    velocity_in <= vel;
    torque_in <= tq;
    temperature_in <= temp;
    error_bits_in <= err;
    fault_in <= flt;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic feed(logic [7:0] id, logic [20:0] raw, logic [23:0] vel, logic [23:0] tq);
    send(CMD_FEEDBACK, id, 3'($urandom()), $urandom(), raw, vel, tq,
         16'($urandom()), 16'($urandom()), 1'($urandom()));
  endtask

  task automatic rehome(logic [2:0] idx, logic [31:0] abs_p);
    send(CMD_REHOME, 8'($urandom()), idx, abs_p, 21'($urandom()), rand24(), rand24(),
         16'($urandom()), 16'($urandom()), 1'($urandom()));
  endtask

  task automatic noise(cmd_t c);
    send(c, 8'($urandom()), 3'($urandom()), $urandom(), 21'($urandom()), rand24(), rand24(),
         16'($urandom()), 16'($urandom()), 1'($urandom()));
  endtask

  // drop push and wait for every predicted beat to come back
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_reg(reg_t idx, logic [47:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic configure(logic [47:0] ids, logic [5:0] rev, logic [20:0] rng,
                           logic [19:0] half, logic [15:0] tmo);
    settle();
    set_reg(REG_ID_TABLE, ids);
    set_reg(REG_REVERSED, {42'd0, rev});
    set_reg(REG_WRAP_RANGE, {27'd0, rng});
    set_reg(REG_WRAP_HALF, {28'd0, half});
    set_reg(REG_TIMEOUT, {32'd0, tmo});
    cfg_wr_en <= 1'b0;
    cur_ids = ids;
  endtask

  task automatic random_item();
    int r;
    int m;
    int s;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      s = $urandom_range(0, 5);
      m = $urandom_range(0, 99);
      // walk the raw position so that wraps come from crossing the range ends
      if (m < 70) walker[s] = walker[s] + 21'($urandom_range(0, 8191)) - 21'd4096;
      else if (m < 90) walker[s] = walker[s] + 21'($urandom_range(0, 1048575)) - 21'd524288;
      else walker[s] = 21'($urandom());
      feed(cur_ids[8*s +: 8], walker[s], rand24(), rand24());
    end else if (r < 85) begin
      noise(CMD_TICK);
    end else if (r < 91) begin
      if ($urandom_range(0, 9) == 0) rehome(3'($urandom_range(6, 7)), $urandom());
      else rehome(3'($urandom_range(0, 5)), $urandom());
    end else if (r < 97) begin
      feed(8'($urandom()), 21'($urandom()), rand24(), rand24());
    end else begin
      noise(CMD_RESERVED);
    end
  endtask

  initial begin
    pop <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      int n;
      n = idle_len(pop_burst);
      if (n > 0) begin
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  initial begin
    logic [20:0] rng;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_ID_TABLE;
    cfg_data <= '0;
    push <= 1'b0;
    command <= CMD_FEEDBACK;
    bus_id <= '0;
    motor_index <= '0;
    abs_position <= '0;
    wrapped_position <= '0;
    velocity_in <= '0;
    torque_in <= '0;
    temperature_in <= '0;
    error_bits_in <= '0;
    fault_in <= 1'b0;
    cur_ids = '0;
    for (int i = 0; i < 6; i++) walker[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: every motor carries id 0, so motor 0 takes them all
    feed(8'h00, 21'd777, rand24(), rand24());
    feed(8'h07, 21'd1, rand24(), rand24());
    noise(CMD_TICK);

    // duplicate id 0x33 on motors 2 and 3; motors 1, 3, 5 reversed
    configure(48'h00_80_33_33_FF_01, 6'b101010, WRAP_RANGE_RST, WRAP_HALF_RST, 16'd3);
    send(CMD_FEEDBACK, 8'h01, 3'd0, 32'd0, 21'h0FFFFF, 24'h7FFFFF, 24'h800000,
         16'hFFFF, 16'hFFFF, 1'b1);
    send(CMD_FEEDBACK, 8'h01, 3'd7, 32'hFFFFFFFF, 21'h100000, 24'd0, 24'd0,
         16'h0000, 16'h0000, 1'b0);
    feed(8'h01, 21'd0, rand24(), rand24());
    feed(8'hFF, 21'd0, 24'h800000, 24'h800000);
    feed(8'h33, 21'd1000, rand24(), rand24());
    feed(8'h77, 21'd5, rand24(), rand24());
    rehome(3'd1, 32'h7FFFFFFF);
    rehome(3'd6, 32'h1234);
    rehome(3'd7, 32'h5678);
    rehome(3'd5, 32'h80000000);
    feed(8'h00, 21'd12345, rand24(), rand24());
    feed(8'hFF, 21'd5, rand24(), rand24());
    // threshold edges on motor 4: a jump of exactly the threshold must not wrap
    feed(8'h80, 21'd0, rand24(), rand24());
    feed(8'h80, 21'd823550, rand24(), rand24());
    feed(8'h80, 21'd0, rand24(), rand24());
    feed(8'h80, 21'(-823551), rand24(), rand24());
    noise(CMD_RESERVED);
    repeat (5) noise(CMD_TICK);
    feed(8'h01, 21'd0, rand24(), rand24());
    noise(CMD_TICK);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: configure(rand_ids(255), 6'd0, WRAP_RANGE_RST, WRAP_HALF_RST, 16'd5);
        1: configure(rand_ids(3), 6'h3F, 21'h1FFFFF, 20'hFFFFF, 16'd0);
        2: configure(rand_ids(255), 6'($urandom()), 21'd0, 20'd0, 16'hFFFF);
        3: begin
          rng = 21'($urandom_range(2, 2097151));
          configure(rand_ids(15), 6'($urandom()), rng, 20'(rng >> 1),
                    16'($urandom_range(1, 30)));
        end
        4: configure(48'hFFFF_FFFF_FFFF, 6'($urandom()), 21'($urandom()), 20'($urandom()),
                     16'd2);
        5: configure({16'($urandom()), 32'($urandom())}, 6'($urandom()), 21'($urandom()),
                     20'($urandom()), 16'($urandom_range(0, 40)));
        default: configure(rand_ids(255), 6'b010101, WRAP_RANGE_RST, WRAP_HALF_RST,
                           TIMEOUT_RST);
      endcase
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 199) == 0) settle();
        random_item();
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_multi_motor_position_unwrap: PASS");
    end else begin
      $display("tb_multi_motor_position_unwrap: FAIL");
    end
    $finish;
  end

endmodule
